/* rtl/btw_pkg.sv */
package btw_pkg;

   localparam int IDX_W      = 6;
   localparam int VAL_W      = 8;
   localparam int CNT_W      = 7;
   localparam int FIFO_DEPTH = 64;

   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_LINK   = 2'd1;
   localparam logic [1:0] MODE_WALK   = 2'd2;

   localparam logic [1:0] RSP_OK       = 2'd0;
   localparam logic [1:0] RSP_FULL     = 2'd1;
   localparam logic [1:0] RSP_OVERFLOW = 2'd2;
   localparam logic [1:0] RSP_EMPTY    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOOKUP,
      ST_PUSH_LEFT,
      ST_PUSH_RIGHT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start_create;
      logic start_link;
      logic start_walk;
      logic start_empty;
      logic fetch;
      logic lookup;
      logic push_left;
      logic push_right;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic root_ok;
      logic last_visit;
   } dp_stat_type;

endpackage

/* rtl/btw_ctrl.sv */
module btw_ctrl
   import btw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_mode,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      req_take;

   assign req_tready = (state_ff == ST_IDLE) && stat.out_free;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_mode == MODE_WALK && stat.root_ok) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:      state_in = ST_LOOKUP;
         ST_LOOKUP:     state_in = ST_PUSH_LEFT;
         ST_PUSH_LEFT:  state_in = ST_PUSH_RIGHT;
         ST_PUSH_RIGHT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.out_free) begin
               state_in = stat.last_visit ? ST_IDLE : ST_FETCH;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_mode)
                  MODE_CREATE: cmd.start_create = 1'b1;
                  MODE_LINK:   cmd.start_link   = 1'b1;
                  MODE_WALK: begin
                     cmd.start_walk  = stat.root_ok;
                     cmd.start_empty = !stat.root_ok;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH:      cmd.fetch      = 1'b1;
         ST_LOOKUP:     cmd.lookup     = 1'b1;
         ST_PUSH_LEFT:  cmd.push_left  = 1'b1;
         ST_PUSH_RIGHT: cmd.push_right = 1'b1;
         ST_EMIT:       cmd.emit       = stat.out_free;
         default: ;
      endcase
   end

endmodule

/* rtl/btw_dpath.sv */
module btw_dpath
   import btw_pkg::*;
#(
   parameter int NODES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_stat_type        stat,
   input  logic [VAL_W-1:0]   req_value,
   input  logic [IDX_W-1:0]   req_parent,
   input  logic [IDX_W-1:0]   req_child,
   input  logic               req_right,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [IDX_W-1:0]   rsp_index,
   output logic [VAL_W-1:0]   rsp_value,
   output logic               rsp_last,
   output logic [1:0]         rsp_status
);

   localparam int AW = $clog2(NODES);
   localparam logic [CNT_W-1:0] NODES_C    = CNT_W'(NODES);
   localparam logic [IDX_W-1:0] LAST_VISIT = IDX_W'(NODES - 1);
   localparam logic [CNT_W-1:0] FIFO_FULL  = CNT_W'(FIFO_DEPTH);

   logic [VAL_W-1:0] val_mem   [NODES];
   logic [IDX_W-1:0] left_mem  [NODES];
   logic [IDX_W-1:0] right_mem [NODES];
   logic [IDX_W-1:0] fifo_mem  [FIFO_DEPTH];

   logic [CNT_W-1:0] next_free_ff;
   logic [IDX_W-1:0] head_ff, tail_ff, visits_ff;
   logic [CNT_W-1:0] count_ff;
   logic             dropped_ff;

   logic [IDX_W-1:0] fifo_rd_ff;
   logic [VAL_W-1:0] val_rd_ff;
   logic [IDX_W-1:0] left_rd_ff, right_rd_ff;

   logic             rsp_valid_ff, rsp_last_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic [1:0]       rsp_status_ff;

   logic             table_full, create_ok, link_ok, out_free, last_visit;
   logic [AW-1:0]    new_addr;
   logic [IDX_W-1:0] kid;
   logic             push_any, push_ok, fifo_we;
   logic [IDX_W-1:0] fifo_wa, fifo_wd;

   assign table_full = next_free_ff >= NODES_C;
   assign create_ok  = cmd.start_create && !table_full;
   assign new_addr   = next_free_ff[AW-1:0];
   assign link_ok    = cmd.start_link && (req_parent != '0)
                       && ({1'b0, req_parent} < NODES_C)
                       && ({1'b0, req_child} < NODES_C);

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_visit = (count_ff == '0) || (visits_ff == LAST_VISIT);

   assign stat.out_free   = out_free;
   assign stat.root_ok    = (req_parent != '0) && ({1'b0, req_parent} < NODES_C);
   assign stat.last_visit = last_visit;

   // node tables
   always_ff @(posedge clock) begin
      if (create_ok) begin
         val_mem[new_addr] <= req_value;
      end
      if (cmd.lookup) begin
         val_rd_ff <= val_mem[fifo_rd_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (create_ok) begin
         left_mem[new_addr] <= '0;
      end else if (link_ok && !req_right) begin
         left_mem[req_parent[AW-1:0]] <= req_child;
      end
      if (cmd.lookup) begin
         left_rd_ff <= left_mem[fifo_rd_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (create_ok) begin
         right_mem[new_addr] <= '0;
      end else if (link_ok && req_right) begin
         right_mem[req_parent[AW-1:0]] <= req_child;
      end
      if (cmd.lookup) begin
         right_rd_ff <= right_mem[fifo_rd_ff[AW-1:0]];
      end
   end

   // walk queue
   assign kid      = cmd.push_right ? right_rd_ff : left_rd_ff;
   assign push_any = (cmd.push_left || cmd.push_right) && (kid != '0);
   assign push_ok  = push_any && (count_ff < FIFO_FULL);
   assign fifo_we  = cmd.start_walk || push_ok;
   assign fifo_wa  = cmd.start_walk ? '0 : tail_ff;
   assign fifo_wd  = cmd.start_walk ? req_parent : kid;

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_wa] <= fifo_wd;
      end
      if (cmd.fetch) begin
         fifo_rd_ff <= fifo_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= CNT_W'(1);
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         visits_ff    <= '0;
         dropped_ff   <= 1'b0;
      end else begin
         if (create_ok) begin
            next_free_ff <= next_free_ff + CNT_W'(1);
         end
         if (cmd.start_walk) begin
            head_ff    <= '0;
            tail_ff    <= IDX_W'(1);
            count_ff   <= CNT_W'(1);
            visits_ff  <= '0;
            dropped_ff <= 1'b0;
         end else if (cmd.fetch) begin
            head_ff   <= head_ff + IDX_W'(1);
            count_ff  <= count_ff - CNT_W'(1);
            visits_ff <= visits_ff + IDX_W'(1);
         end else if (push_ok) begin
            tail_ff  <= tail_ff + IDX_W'(1);
            count_ff <= count_ff + CNT_W'(1);
         end else if (push_any) begin
            dropped_ff <= 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.start_create || cmd.start_empty || cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_create) begin
         rsp_index_ff  <= table_full ? '0 : next_free_ff[IDX_W-1:0];
         rsp_value_ff  <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= table_full ? RSP_FULL : RSP_OK;
      end else if (cmd.start_empty) begin
         rsp_index_ff  <= '0;
         rsp_value_ff  <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= RSP_EMPTY;
      end else if (cmd.emit) begin
         rsp_index_ff  <= fifo_rd_ff;
         rsp_value_ff  <= val_rd_ff;
         rsp_last_ff   <= last_visit;
         rsp_status_ff <= (last_visit && (count_ff != '0 || dropped_ff)) ? RSP_OVERFLOW
                                                                          : RSP_OK;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_FULL)
      else $error("walk queue count above depth");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NODES_C)
      else $error("free index past table size");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.start_create || cmd.start_empty) |-> out_free)
      else $error("result register overwritten");

   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (push_any && !push_ok) |=> dropped_ff)
      else $error("dropped push not flagged");
`endif

endmodule

/* rtl/binary_tree_level_order_walk_core.sv */
// Binary tree node table with level-order walk. A transaction with mode create
// stores a node at the next free index (1 up to NODES-1) and answers with that
// index, or with status full; link sets a left or right child and answers
// nothing; walk answers with one result per visited node in level order, the
// last one marked by rsp_tlast, or with status empty for a root of 0 or not
// below NODES. For each visited node a walk does a queue read, a table read,
// two queue pushes and a result load, in that order, set by the single-port
// walk queue and node tables, for up to NODES-1 visits; the result load waits
// while the result channel stalls. A finished result sits in an output
// register; the next request is taken only once that register is empty or
// its result is being read in the same cycle.
module binary_tree_level_order_walk_core
   import btw_pkg::*;
#(
   parameter int NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // node_value[7:0], parent_index[13:8], child_index[19:14]
   input  logic [2:0]  req_tuser,  // mode[1:0], right_side[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // out_index[5:0], out_value[13:6]
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   ctrl_cmd_type     cmd;
   dp_stat_type      stat;
   logic [IDX_W-1:0] rsp_index;
   logic [VAL_W-1:0] rsp_value;

   btw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser[1:0]),
      .stat       (stat),
      .cmd        (cmd)
   );

   btw_dpath #(
      .NODES (NODES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_value  (req_tdata[7:0]),
      .req_parent (req_tdata[13:8]),
      .req_child  (req_tdata[19:14]),
      .req_right  (req_tuser[2]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_index  (rsp_index),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, rsp_value, rsp_index};

endmodule

/* tb/binary_tree_level_order_walk_core_tb.sv */
module binary_tree_level_order_walk_core_tb;
   import btw_pkg::*;

   localparam int          TREE_NODES = 64;
   localparam int          RUN_LIMIT  = 1_500_000;
   localparam int          SETTLE     = 40;
   localparam logic [1:0]  MODE_NONE  = 2'd3;

   typedef struct packed {
      bit [5:0] idx;
      bit [7:0] val;
      bit       last;
      bit [1:0] status;
   } tree_rsp_t;

   typedef struct packed {
      bit [1:0]  mode;
      bit [7:0]  value;
      bit [5:0]  parent;
      bit [5:0]  child;
      bit        side;
      bit        hold;      // wait for all pending results before sending
      bit        typed;     // use typed_rsp instead of the table model
      tree_rsp_t typed_rsp;
   } tree_req_t;

   localparam tree_rsp_t NO_RSP = '0;
   localparam int        DIR_N  = 23;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // node_value[7:0], parent_index[13:8], child_index[19:14]
   logic [2:0]  req_tuser  = '0;   // mode[1:0], right_side[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // out_index[5:0], out_value[13:6]
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;         // status[1:0]

   binary_tree_level_order_walk_core #(
      .NODES(TREE_NODES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // node table mirror
   bit [7:0]  node_val [64];
   bit [5:0]  left_of  [64];
   bit [5:0]  right_of [64];
   bit [6:0]  next_free = 7'd1;

   tree_req_t req_q [$];
   tree_rsp_t tree_rsp_q [$];
   tree_req_t dir_rows [DIR_N];
   int        sent_cnt  = 0;
   int        err_cnt   = 0;
   int        made      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic tree_table_step(input tree_req_t r, ref tree_rsp_t outs[$]);
      bit [5:0]    ring [64];
      bit [5:0]    head, tail, cur;
      bit [5:0]    kids [2];
      int unsigned cnt, visits;
      bit          dropped, fin;
      tree_rsp_t   rsp;
      outs.delete();
      case (r.mode)
         MODE_CREATE: begin
            if (next_free >= TREE_NODES) begin
               outs.push_back(tree_rsp_t'{6'd0, 8'd0, 1'b1, RSP_FULL});
            end else begin
               node_val[next_free[5:0]] = r.value;
               left_of[next_free[5:0]]  = '0;
               right_of[next_free[5:0]] = '0;
               outs.push_back(tree_rsp_t'{next_free[5:0], 8'd0, 1'b1, RSP_OK});
               next_free++;
            end
         end
         MODE_LINK: begin
            if (r.parent != 0 && r.parent < TREE_NODES && r.child < TREE_NODES) begin
               if (r.side) right_of[r.parent] = r.child;
               else        left_of[r.parent]  = r.child;
            end
         end
         MODE_WALK: begin
            if (r.parent == 0 || r.parent >= TREE_NODES) begin
               outs.push_back(tree_rsp_t'{6'd0, 8'd0, 1'b1, RSP_EMPTY});
            end else begin
               head = '0;
               tail = '0;
               ring[tail] = r.parent;
               tail++;
               cnt = 1;
               visits = 0;
               dropped = 1'b0;
               while (cnt > 0 && visits < TREE_NODES - 1) begin
                  cur = ring[head];
                  head++;
                  cnt--;
                  visits++;
                  kids[0] = left_of[cur];
                  kids[1] = right_of[cur];
                  for (int j = 0; j < 2; j++) begin
                     if (kids[j] != 0) begin
                        if (cnt >= FIFO_DEPTH) begin
                           dropped = 1'b1;
                        end else begin
                           ring[tail] = kids[j];
                           tail++;
                           cnt++;
                        end
                     end
                  end
                  fin = (cnt == 0) || (visits >= TREE_NODES - 1);
                  rsp.idx    = cur;
                  rsp.val    = node_val[cur];
                  rsp.last   = fin;
                  rsp.status = (fin && (cnt > 0 || dropped)) ? RSP_OVERFLOW : RSP_OK;
                  outs.push_back(rsp);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic add_req(bit [1:0] m, bit [7:0] v, bit [5:0] p, bit [5:0] c, bit s);
      tree_req_t r;
      r = '0;
      r.mode   = m;
      r.value  = v;
      r.parent = p;
      r.child  = c;
      r.side   = s;
      r.hold   = ($urandom_range(0, 39) == 0);
      req_q.push_back(r);
      if (m == MODE_CREATE && made < TREE_NODES - 1) made++;
   endtask

   function automatic bit [5:0] any_node();
      return 6'($urandom_range(1, made));
   endfunction

   task automatic build_random_reqs();
      int       target, sel, k, j, lim;
      bit [5:0] pool [64];
      bit [5:0] tmp, p, c;
      bit [1:0] used [64];
      bit       s;
      target = req_q.size() + 430;
      while (req_q.size() < target) begin
         sel = $urandom_range(0, 99);
         if (sel < ((made < TREE_NODES - 1) ? 30 : 4)) begin
            repeat ($urandom_range(1, 10))
               add_req(MODE_CREATE, 8'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
         end else if (sel < 70) begin
            // well-formed tree over a random subset, then walk it
            lim = (made < 12) ? made : 12;
            k = ($urandom_range(0, 9) == 0) ? made : $urandom_range(1, lim);
            for (int i = 0; i < made; i++) pool[i] = 6'(i + 1);
            for (int i = made - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = pool[i];
               pool[i] = pool[j];
               pool[j] = tmp;
            end
            for (int i = 0; i < k; i++) begin
               add_req(MODE_LINK, 8'($urandom), pool[i], 6'd0, 1'b0);
               add_req(MODE_LINK, 8'($urandom), pool[i], 6'd0, 1'b1);
               used[i] = 2'b00;
            end
            for (int i = 1; i < k; i++) begin
               j = $urandom_range(0, i - 1);
               while (used[j] == 2'b11) j = (j + 1) % i;
               if (used[j][0])      s = 1'b1;
               else if (used[j][1]) s = 1'b0;
               else                 s = 1'($urandom_range(0, 1));
               used[j][s] = 1'b1;
               add_req(MODE_LINK, 8'($urandom), pool[j], pool[i], s);
            end
            add_req(MODE_WALK, 8'($urandom), pool[0], 6'($urandom), 1'($urandom));
            if ($urandom_range(0, 1))
               add_req(MODE_WALK, 8'($urandom), pool[$urandom_range(0, k - 1)],
                       6'($urandom), 1'($urandom));
         end else if (sel < 80) begin
            // back edge or self loop
            p = any_node();
            c = ($urandom_range(0, 2) == 0) ? p : any_node();
            add_req(MODE_LINK, 8'($urandom), p, c, 1'($urandom));
            add_req(MODE_WALK, 8'($urandom), c, 6'($urandom), 1'($urandom));
            add_req(MODE_WALK, 8'($urandom), p, 6'($urandom), 1'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0: add_req(MODE_CREATE, 8'($urandom), 6'($urandom), 6'($urandom),
                          1'($urandom));
               1: begin
                  // a parent that was never created only gets its links written
                  p = ($urandom_range(0, 3) == 0) ? 6'd0 :
                      ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : any_node();
                  c = ($urandom_range(0, 3) == 0) ? 6'd0 : any_node();
                  add_req(MODE_LINK, 8'($urandom), p, c, 1'($urandom));
               end
               2: begin
                  p = ($urandom_range(0, 3) == 0) ? 6'd0 : any_node();
                  add_req(MODE_WALK, 8'($urandom), p, 6'($urandom), 1'($urandom));
               end
               default: add_req(MODE_NONE, 8'($urandom), 6'($urandom), 6'($urandom),
                                1'($urandom));
            endcase
         end
      end
   endtask

   // receiver stall pattern, its mode reshuffled from a free-running counter
   int unsigned rdy_cnt  = 0;
   int unsigned rdy_mode = 0;
   always @(posedge clock) begin
      rdy_cnt <= rdy_cnt + 1;
      if (rdy_cnt % 48 == 0) rdy_mode <= $urandom_range(0, 3);
      case (rdy_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (rdy_cnt[1:0] == 2'd0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // result check and request driver share one block so queue order is fixed
   int burst_left = 1;
   int gap_left   = 0;
   always @(posedge clock) begin : xfer
      tree_rsp_t got, want;
      tree_rsp_t outs [$];
      tree_req_t r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = tree_rsp_t'{rsp_tdata[5:0], rsp_tdata[13:6], rsp_tlast, rsp_tuser};
            if (tree_rsp_q.size() == 0) begin
               $error("unexpected result: index %0d value %0d last %0d status %0d",
                      got.idx, got.val, got.last, got.status);
               err_cnt++;
            end else begin
               want = tree_rsp_q.pop_front();
               if (got.idx != want.idx) begin
                  $error("out_index: expected %0d, got %0d", want.idx, got.idx);
                  err_cnt++;
               end
               if (got.val != want.val) begin
                  $error("out_value: expected %0d, got %0d", want.val, got.val);
                  err_cnt++;
               end
               if (got.last != want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  err_cnt++;
               end
               if (got.status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  err_cnt++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            r = req_q[sent_cnt];
            tree_table_step(r, outs);
            if (r.typed) tree_rsp_q.push_back(r.typed_rsp);
            else foreach (outs[i]) tree_rsp_q.push_back(outs[i]);
            sent_cnt++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 12);
               case ($urandom_range(0, 5))
                  0, 1:    gap_left = 0;
                  5:       gap_left = $urandom_range(10, 40);
                  default: gap_left = $urandom_range(1, 4);
               endcase
            end
         end

         if (!req_tvalid || req_tready) begin
            if (sent_cnt >= req_q.size()) begin
               req_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (req_q[sent_cnt].hold && tree_rsp_q.size() != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               r = req_q[sent_cnt];
               req_tdata  <= {4'd0, r.child, r.parent, r.value};
               req_tuser  <= {r.side, r.mode};
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("binary_tree_level_order_walk_core_tb: FAIL");
      $finish;
   end

   initial begin : run
      dir_rows = '{
         // walk from an empty root right after reset
         '{MODE_WALK,   8'hFF, 6'd0,  6'd63, 1'b1, 1'b0, 1'b1, '{6'd0, 8'd0, 1'b1, RSP_EMPTY}},
         '{MODE_CREATE, 8'h00, 6'd63, 6'd63, 1'b1, 1'b0, 1'b1, '{6'd1, 8'd0, 1'b1, RSP_OK}},
         '{MODE_CREATE, 8'hFF, 6'd0,  6'd0,  1'b0, 1'b0, 1'b1, '{6'd2, 8'd0, 1'b1, RSP_OK}},
         '{MODE_CREATE, 8'hA5, 6'd21, 6'd42, 1'b0, 1'b0, 1'b1, '{6'd3, 8'd0, 1'b1, RSP_OK}},
         '{MODE_CREATE, 8'h5A, 6'd42, 6'd21, 1'b1, 1'b0, 1'b1, '{6'd4, 8'd0, 1'b1, RSP_OK}},
         '{MODE_CREATE, 8'h80, 6'd0,  6'd0,  1'b0, 1'b0, 1'b1, '{6'd5, 8'd0, 1'b1, RSP_OK}},
         '{MODE_LINK,   8'h00, 6'd1,  6'd2,  1'b0, 1'b0, 1'b0, NO_RSP},
         '{MODE_LINK,   8'hFF, 6'd1,  6'd3,  1'b1, 1'b0, 1'b0, NO_RSP},
         '{MODE_LINK,   8'h00, 6'd2,  6'd4,  1'b1, 1'b0, 1'b0, NO_RSP},
         '{MODE_LINK,   8'h00, 6'd3,  6'd5,  1'b0, 1'b0, 1'b0, NO_RSP},
         '{MODE_WALK,   8'h00, 6'd1,  6'd0,  1'b0, 1'b1, 1'b0, NO_RSP},
         // parent 0 is ignored
         '{MODE_LINK,   8'hFF, 6'd0,  6'd3,  1'b1, 1'b0, 1'b0, NO_RSP},
         '{MODE_NONE,   8'hFF, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0, NO_RSP},
         '{MODE_WALK,   8'h00, 6'd0,  6'd0,  1'b0, 1'b0, 1'b1, '{6'd0, 8'd0, 1'b1, RSP_EMPTY}},
         // self loop, then walks that run into it
         '{MODE_LINK,   8'h00, 6'd4,  6'd4,  1'b0, 1'b0, 1'b0, NO_RSP},
         '{MODE_WALK,   8'h00, 6'd4,  6'd0,  1'b0, 1'b0, 1'b0, NO_RSP},
         '{MODE_WALK,   8'h00, 6'd1,  6'd0,  1'b0, 1'b0, 1'b0, NO_RSP},
         '{MODE_LINK,   8'h00, 6'd4,  6'd0,  1'b0, 1'b0, 1'b0, NO_RSP},
         '{MODE_LINK,   8'h00, 6'd5,  6'd1,  1'b1, 1'b0, 1'b0, NO_RSP},
         '{MODE_WALK,   8'h00, 6'd3,  6'd0,  1'b0, 1'b0, 1'b0, NO_RSP},
         '{MODE_LINK,   8'h00, 6'd5,  6'd0,  1'b1, 1'b0, 1'b0, NO_RSP},
         '{MODE_WALK,   8'h00, 6'd5,  6'd0,  1'b0, 1'b0, 1'b0, NO_RSP},
         '{MODE_WALK,   8'h00, 6'd1,  6'd0,  1'b0, 1'b0, 1'b0, NO_RSP}
      };
      foreach (dir_rows[i]) begin
         req_q.push_back(dir_rows[i]);
         if (dir_rows[i].mode == MODE_CREATE) made++;
      end
      build_random_reqs();

      do @(posedge clock);
      while (sent_cnt < req_q.size() || tree_rsp_q.size() != 0);
      repeat (SETTLE) @(posedge clock);

      if (err_cnt == 0 && tree_rsp_q.size() == 0) begin
         $display("binary_tree_level_order_walk_core_tb: PASS");
      end else begin
         $display("binary_tree_level_order_walk_core_tb: FAIL");
      end
      $finish;
   end

endmodule

/* binary_tree_level_order_walk_core.f */
rtl/btw_pkg.sv
rtl/btw_ctrl.sv
rtl/btw_dpath.sv
rtl/binary_tree_level_order_walk_core.sv
tb/binary_tree_level_order_walk_core_tb.sv
